[sv/lavm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_pkg
// Shared widths, latencies and word layouts of the look-at view matrix builder.
// ----------------------------------------------------------------------------
package lavm_pkg;

  localparam int FRAC_BITS = 16;

  localparam int NIW      = FRAC_BITS + 34;
  localparam int NW       = FRAC_BITS + 33;
  localparam int NWP      = ((NW + 7) / 8) * 8;
  localparam int NCH      = NWP / 8;
  localparam int PW       = $clog2(NWP);
  localparam int VW       = FRAC_BITS + 2;
  localparam int TW       = FRAC_BITS + 3;
  localparam int QW       = FRAC_BITS + 1;
  localparam int SQ_STEPS = 31;
  localparam int NORM_LAT = FRAC_BITS + 40;
  localparam int LAT      = 2 * NORM_LAT + 9;
  localparam int CW       = 2 * FRAC_BITS + 5;
  localparam int PDW      = FRAC_BITS + 35;
  localparam int SDW      = FRAC_BITS + 38;
  localparam int FW       = 18;
  localparam int XW       = (TW > FW) ? TW : FW;
  localparam int HALF     = 1 << (FRAC_BITS - 1);

  typedef logic signed [NIW-1:0] nin_t;
  typedef logic signed [VW-1:0]  vec_t;
  typedef logic signed [TW-1:0]  tup_t;

  typedef struct packed {
    logic [2:0][31:0] up;
    logic [2:0][31:0] target;
    logic [2:0][31:0] eye;
  } in_word_t;

  typedef struct packed {
    logic [5:0]        pad;
    logic [31:0]       back_off;
    logic [2:0][FW-1:0] back;
    logic [31:0]       up_off;
    logic [2:0][FW-1:0] up;
    logic [31:0]       side_off;
    logic [2:0][FW-1:0] side;
  } out_word_t;

  function automatic logic [FW-1:0] fld18(input tup_t v);
    logic signed [XW-1:0] w;
    w = XW'(v);
    return w[FW-1:0];
  endfunction

endpackage

[sv/look_at_view_matrix_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix_builder
// Builds the upper three rows of a look-at view matrix from eye, target and
// up hint in signed fixed point.
//
//   port group | dir | words
//   s_axis     | in  | eye, target, up (9 x 32 bit)
//   m_axis     | out | side, true up, back rows with offsets
//
// One word accepted per cycle unless the pipeline stalls; the latency
// is set by the two normalizers (square root and divide stages).
// A two-word output queue follows the last stage; the pipeline stalls only
// when that queue is full and the last stage holds a word.
// Reset clears the stage valid bits and the output queue.
// ----------------------------------------------------------------------------
module look_at_view_matrix_builder (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // side_x, side_y, side_z, side_off, true_up_x, true_up_y, true_up_z,
  // true_up_off, back_x, back_y, back_z, back_off, zero fill
  output logic [263:0] m_axis_tdata
);
  import lavm_pkg::*;

  localparam int EYE_N  = 2 * NORM_LAT + 6;
  localparam int BACK_N = NORM_LAT + 8;

  in_word_t  in_w;
  out_word_t out_w;
  logic      en, acc, push, pop;

  logic [LAT-1:0]     vld_q;
  nin_t               d_q      [3];
  logic signed [31:0] eye_dl_q [EYE_N][3];
  logic signed [31:0] up_dl_q  [NORM_LAT+1][3];
  vec_t               back_n   [3];
  vec_t               side_n   [3];
  nin_t               pr1_q    [6];
  nin_t               sraw_q   [3];
  vec_t               back_dl_q [BACK_N][3];
  vec_t               side_dl_q [6][3];
  logic signed [CW-1:0] pr2_q  [6];
  logic signed [CW-1:0] ur_q   [3];
  tup_t               tup_q    [3];
  tup_t               tup_d    [3];
  tup_t               tup_dl_q [3][3];
  logic signed [PDW-1:0] po_q  [3][3];
  logic signed [SDW-1:0] sum_q [3];
  logic [31:0]        off_q    [3];
  logic [31:0]        off_d    [3];

  out_word_t fifo_q [2];
  logic      wr_q, rd_q;
  logic [1:0] cnt_q;

  assign in_w          = in_word_t'(s_axis_tdata);
  assign en            = (cnt_q != 2'd2) || !vld_q[LAT-1];
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;
  assign push          = en && vld_q[LAT-1];
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = fifo_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], acc};
    end
  end

  lavm_norm u_norm_back (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (d_q),
    .unit_o (back_n)
  );

  lavm_norm u_norm_side (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (sraw_q),
    .unit_o (side_n)
  );

  always_comb begin
    logic [CW-1:0] um, ru;
    for (int i = 0; i < 3; i++) begin
      um = ur_q[i][CW-1] ? CW'(-ur_q[i]) : CW'(ur_q[i]);
      ru = (um + CW'(HALF)) >> FRAC_BITS;
      tup_d[i] = ur_q[i][CW-1] ? -TW'(ru) : TW'(ru);
    end
  end

  always_comb begin
    logic [SDW-1:0] om, rm;
    for (int r = 0; r < 3; r++) begin
      om = sum_q[r][SDW-1] ? SDW'(-sum_q[r]) : SDW'(sum_q[r]);
      rm = (om + SDW'(HALF)) >> FRAC_BITS;
      if (sum_q[r][SDW-1]) begin
        if (rm > SDW'(64'd2147483648)) off_d[r] = 32'h8000_0000;
        else                           off_d[r] = 32'(-rm);
      end else begin
        if (rm > SDW'(64'd2147483647)) off_d[r] = 32'h7fff_ffff;
        else                           off_d[r] = 32'(rm);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i]        <= NIW'($signed(in_w.eye[i])) - NIW'($signed(in_w.target[i]));
        eye_dl_q[0][i] <= $signed(in_w.eye[i]);
        up_dl_q[0][i]  <= $signed(in_w.up[i]);
      end
      for (int k = 1; k < EYE_N; k++) eye_dl_q[k] <= eye_dl_q[k-1];
      for (int k = 1; k <= NORM_LAT; k++) up_dl_q[k] <= up_dl_q[k-1];

      pr1_q[0] <= NIW'(up_dl_q[NORM_LAT][1]) * NIW'(back_n[2]);
      pr1_q[1] <= NIW'(up_dl_q[NORM_LAT][2]) * NIW'(back_n[1]);
      pr1_q[2] <= NIW'(up_dl_q[NORM_LAT][2]) * NIW'(back_n[0]);
      pr1_q[3] <= NIW'(up_dl_q[NORM_LAT][0]) * NIW'(back_n[2]);
      pr1_q[4] <= NIW'(up_dl_q[NORM_LAT][0]) * NIW'(back_n[1]);
      pr1_q[5] <= NIW'(up_dl_q[NORM_LAT][1]) * NIW'(back_n[0]);
      for (int i = 0; i < 3; i++) sraw_q[i] <= pr1_q[2*i] - pr1_q[2*i+1];

      back_dl_q[0] <= back_n;
      for (int k = 1; k < BACK_N; k++) back_dl_q[k] <= back_dl_q[k-1];

      pr2_q[0] <= CW'(back_dl_q[NORM_LAT+1][1]) * CW'(side_n[2]);
      pr2_q[1] <= CW'(back_dl_q[NORM_LAT+1][2]) * CW'(side_n[1]);
      pr2_q[2] <= CW'(back_dl_q[NORM_LAT+1][2]) * CW'(side_n[0]);
      pr2_q[3] <= CW'(back_dl_q[NORM_LAT+1][0]) * CW'(side_n[2]);
      pr2_q[4] <= CW'(back_dl_q[NORM_LAT+1][0]) * CW'(side_n[1]);
      pr2_q[5] <= CW'(back_dl_q[NORM_LAT+1][1]) * CW'(side_n[0]);
      for (int i = 0; i < 3; i++) ur_q[i] <= pr2_q[2*i] - pr2_q[2*i+1];
      tup_q <= tup_d;

      side_dl_q[0] <= side_n;
      for (int k = 1; k < 6; k++) side_dl_q[k] <= side_dl_q[k-1];
      tup_dl_q[0] <= tup_q;
      for (int k = 1; k < 3; k++) tup_dl_q[k] <= tup_dl_q[k-1];

      for (int i = 0; i < 3; i++) begin
        po_q[0][i] <= PDW'(side_dl_q[2][i]) * PDW'(eye_dl_q[EYE_N-1][i]);
        po_q[1][i] <= PDW'(tup_q[i]) * PDW'(eye_dl_q[EYE_N-1][i]);
        po_q[2][i] <= PDW'(back_dl_q[NORM_LAT+4][i]) * PDW'(eye_dl_q[EYE_N-1][i]);
      end
      for (int r = 0; r < 3; r++) begin
        sum_q[r] <= -(SDW'(po_q[r][0]) + SDW'(po_q[r][1]) + SDW'(po_q[r][2]));
      end
      off_q <= off_d;
    end
  end

  always_comb begin
    out_w          = '0;
    out_w.side_off = off_q[0];
    out_w.up_off   = off_q[1];
    out_w.back_off = off_q[2];
    for (int i = 0; i < 3; i++) begin
      out_w.side[i] = fld18(TW'(side_dl_q[5][i]));
      out_w.up[i]   = fld18(tup_dl_q[2][i]);
      out_w.back[i] = fld18(TW'(back_dl_q[BACK_N-1][i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= out_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

[sv/lavm_norm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_norm
// Pipelined 3-vector normalizer: align, sum of squares, bit-serial square
// root over stages, then one quotient bit per stage for each lane.
// ----------------------------------------------------------------------------
module lavm_norm (
  input  logic           clk_i,
  input  logic           en_i,
  input  lavm_pkg::nin_t vec_i  [3],
  output lavm_pkg::vec_t unit_o [3]
);
  import lavm_pkg::*;

  function automatic logic [2:0] lead8(input logic [7:0] b);
    logic [2:0] p;
    p = '0;
    for (int k = 0; k < 8; k++) if (b[k]) p = 3'(k);
    return p;
  endfunction

  logic [NW-1:0]  mag_a_q [3];
  logic [2:0]     neg_a_q;
  logic [NW-1:0]  mag_b_q [3];
  logic [NW-1:0]  mx_b_q, mx_b_d;
  logic [2:0]     neg_b_q;
  logic [NW-1:0]  mag_c_q [3];
  logic [2:0]     neg_c_q;
  logic [NCH-1:0] chf_c_q, chf_c_d;
  logic [2:0]     chp_c_q [NCH];
  logic [2:0]     chp_c_d [NCH];
  logic           z_c_q;
  logic [NW-1:0]  mag_d_q [3];
  logic [2:0]     neg_d_q;
  logic [PW-1:0]  pos_d_q, pos_d_d;
  logic           z_d_q;
  logic [29:0]    m_e_q [3];
  logic [29:0]    m_e_d [3];
  logic [2:0]     neg_e_q;
  logic           z_e_q;
  logic [59:0]    sq_f_q [3];
  logic [29:0]    m_f_q [3];
  logic [2:0]     neg_f_q;
  logic           z_f_q;
  logic [61:0]    s_g_q;
  logic [29:0]    m_g_q [3];
  logic [2:0]     neg_g_q;
  logic           z_g_q;

  logic [61:0]    sq_s_q [SQ_STEPS];
  logic [61:0]    sq_r_q [SQ_STEPS];
  logic [29:0]    sq_m_q [SQ_STEPS][3];
  logic [2:0]     sq_n_q [SQ_STEPS];
  logic           sq_z_q [SQ_STEPS];

  logic [31:0]    dv_rem_q [QW][3];
  logic [QW-1:0]  dv_q_q   [QW][3];
  logic [30:0]    dv_r_q   [QW];
  logic [2:0]     dv_n_q   [QW];
  logic           dv_z_q   [QW];

  always_comb begin
    mx_b_d = mag_a_q[0];
    if (mag_a_q[1] > mx_b_d) mx_b_d = mag_a_q[1];
    if (mag_a_q[2] > mx_b_d) mx_b_d = mag_a_q[2];
  end

  always_comb begin
    logic [NWP-1:0] mxp;
    mxp = NWP'(mx_b_q);
    for (int c = 0; c < NCH; c++) begin
      chf_c_d[c] = |mxp[c*8 +: 8];
      chp_c_d[c] = lead8(mxp[c*8 +: 8]);
    end
  end

  always_comb begin
    pos_d_d = '0;
    for (int c = 0; c < NCH; c++) begin
      if (chf_c_q[c]) pos_d_d = PW'(c * 8) + PW'(chp_c_q[c]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos_d_q >= PW'(30)) begin
        m_e_d[i] = 30'(mag_d_q[i] >> (pos_d_q - PW'(29)));
      end else begin
        m_e_d[i] = 30'(mag_d_q[i] << (PW'(29) - pos_d_q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        neg_a_q[i] <= vec_i[i][NIW-1];
        mag_a_q[i] <= vec_i[i][NIW-1] ? NW'(-vec_i[i]) : NW'(vec_i[i]);
        mag_b_q[i] <= mag_a_q[i];
        mag_c_q[i] <= mag_b_q[i];
        mag_d_q[i] <= mag_c_q[i];
        m_e_q[i]   <= m_e_d[i];
        sq_f_q[i]  <= m_e_q[i] * m_e_q[i];
        m_f_q[i]   <= m_e_q[i];
        m_g_q[i]   <= m_f_q[i];
      end
      mx_b_q  <= mx_b_d;
      neg_b_q <= neg_a_q;
      chf_c_q <= chf_c_d;
      chp_c_q <= chp_c_d;
      z_c_q   <= ~|chf_c_d;
      neg_c_q <= neg_b_q;
      pos_d_q <= pos_d_d;
      z_d_q   <= z_c_q;
      neg_d_q <= neg_c_q;
      z_e_q   <= z_d_q;
      neg_e_q <= neg_d_q;
      z_f_q   <= z_e_q;
      neg_f_q <= neg_e_q;
      s_g_q   <= 62'(sq_f_q[0]) + 62'(sq_f_q[1]) + 62'(sq_f_q[2]);
      z_g_q   <= z_f_q;
      neg_g_q <= neg_f_q;
    end
  end

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
    localparam logic [61:0] BIT = 62'(1) << (2 * (SQ_STEPS - 1 - j));
    logic [61:0] s_in, r_in, s_d, r_d, t;
    logic [29:0] m_in [3];
    logic [2:0]  n_in;
    logic        z_in;
    if (j == 0) begin : g_first
      assign s_in = s_g_q;
      assign r_in = '0;
      assign m_in = m_g_q;
      assign n_in = neg_g_q;
      assign z_in = z_g_q;
    end else begin : g_next
      assign s_in = sq_s_q[j-1];
      assign r_in = sq_r_q[j-1];
      assign m_in = sq_m_q[j-1];
      assign n_in = sq_n_q[j-1];
      assign z_in = sq_z_q[j-1];
    end
    always_comb begin
      t = r_in + BIT;
      if (s_in >= t) begin
        s_d = s_in - t;
        r_d = (r_in >> 1) + BIT;
      end else begin
        s_d = s_in;
        r_d = r_in >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_s_q[j] <= s_d;
        sq_r_q[j] <= r_d;
        sq_m_q[j] <= m_in;
        sq_n_q[j] <= n_in;
        sq_z_q[j] <= z_in;
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_dv
    logic [31:0]   rem_in [3];
    logic [QW-1:0] q_in   [3];
    logic [30:0]   r_in;
    logic [2:0]    n_in;
    logic          z_in;
    logic [31:0]   rem_d  [3];
    logic [QW-1:0] q_d    [3];
    if (j == 0) begin : g_first
      assign r_in = sq_r_q[SQ_STEPS-1][30:0];
      assign n_in = sq_n_q[SQ_STEPS-1];
      assign z_in = sq_z_q[SQ_STEPS-1];
      for (genvar i = 0; i < 3; i++) begin : g_ln
        assign rem_in[i] = 32'(sq_m_q[SQ_STEPS-1][i]);
        assign q_in[i]   = '0;
      end
    end else begin : g_next
      assign r_in   = dv_r_q[j-1];
      assign n_in   = dv_n_q[j-1];
      assign z_in   = dv_z_q[j-1];
      assign rem_in = dv_rem_q[j-1];
      assign q_in   = dv_q_q[j-1];
    end
    always_comb begin
      logic [31:0] rr;
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= {1'b0, r_in}) begin
          rr     = rem_in[i] - {1'b0, r_in};
          q_d[i] = QW'({q_in[i], 1'b1});
        end else begin
          rr     = rem_in[i];
          q_d[i] = QW'({q_in[i], 1'b0});
        end
        rem_d[i] = rr << 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_rem_q[j] <= rem_d;
        dv_q_q[j]   <= q_d;
        dv_r_q[j]   <= r_in;
        dv_n_q[j]   <= n_in;
        dv_z_q[j]   <= z_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_z_q[QW-1]) begin
          unit_o[i] <= '0;
        end else if (dv_n_q[QW-1][i]) begin
          unit_o[i] <= -VW'({1'b0, dv_q_q[QW-1][i]});
        end else begin
          unit_o[i] <= VW'({1'b0, dv_q_q[QW-1][i]});
        end
      end
    end
  end

endmodule

[sv/lavm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_checker
// Port-level checks for the look-at view matrix builder.
// ----------------------------------------------------------------------------
module lavm_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [287:0] s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [263:0] m_axis_tdata
);
  import lavm_pkg::*;

  localparam int ONE = 1 << FRAC_BITS;

  out_word_t w;

  assign w = out_word_t'(m_axis_tdata);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("input word changed while stalled");

  a_back_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (w.back == '0) |->
      (w.back_off == '0) && (w.side == '0) && (w.up == '0))
    else $error("zero back row with nonzero dependents");

  a_side_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (w.side == '0) |->
      (w.side_off == '0) && (w.up == '0) && (w.up_off == '0))
    else $error("zero side row with nonzero dependents");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (FRAC_BITS > 16) ||
      (($signed(w.back[0]) >= -ONE) && ($signed(w.back[0]) <= ONE) &&
       ($signed(w.side[0]) >= -ONE) && ($signed(w.side[0]) <= ONE)))
    else $error("unit component out of range");

endmodule

bind look_at_view_matrix_builder lavm_checker u_lavm_checker (.*);
